// File: rtl/core/fvn_pkg.sv
// shared constants, types and helper functions of the fractal value noise block
package fvn_pkg;

  // coordinate format
  localparam int COORD_BITS = 20;
  localparam int FRAC_BITS  = 4;
  localparam int MAX_SCALE  = 12;
  localparam int MAX_K      = MAX_SCALE + FRAC_BITS;
  localparam int SNAP_W     = ((COORD_BITS > MAX_K + 1) ? COORD_BITS : MAX_K + 1) + 1;
  localparam int SHIFT_W    = $clog2(MAX_K + 1);

  // register and datapath widths
  localparam int MODE_W      = 2;
  localparam int SCALE_W     = 4;
  localparam int PERS_W      = 16;
  localparam int WGT_W       = 18;
  localparam int WGT_FRAC    = 15;
  localparam int ACC_W       = 22;
  localparam int OUT_W       = 20;
  localparam int HASH_W      = 32;
  localparam int NOISE_W     = 16;
  localparam int NUM_CELLS   = 4;
  localparam int LANES       = 8;
  localparam int CELL_STAGES = 9;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;

  // noise modes
  localparam logic [MODE_W-1:0] MODE_RANDOM  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SMOOTH  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FRACTAL = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;

  // register indexes
  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_SCALE = 2'd1;
  localparam logic [1:0] REG_PERS  = 2'd2;

  // reset values and fixed scales
  localparam logic [SCALE_W-1:0] SCALE_RESET = 4'd5;
  localparam logic [SCALE_W-1:0] SCALE_LIMIT = 4'd12;
  localparam logic [PERS_W-1:0]  PERS_RESET  = 16'd16384;
  localparam logic [SCALE_W-1:0] OCT_SCALE [NUM_CELLS] = '{4'd10, 4'd8, 4'd6, 4'd4};

  // octave weighting and output offsets
  localparam logic [WGT_W-1:0]        WEIGHT_ONE       = 18'd32768;
  localparam logic signed [ACC_W-1:0] ACC_SEED_PLAIN   = 22'sd32768;
  localparam logic signed [ACC_W-1:0] ACC_SEED_FRACTAL = 22'sd131072;
  localparam logic signed [ACC_W-1:0] OUT_BIAS         = 22'sd32768;
  localparam logic signed [ACC_W-1:0] OUT_MAX          = 22'sd524287;
  localparam logic signed [ACC_W-1:0] OUT_MIN          = -22'sd524288;
  localparam logic signed [NOISE_W:0] NOISE_BIAS       = 17'sd32768;

  // lattice hash constants
  localparam logic [HASH_W-1:0] HASH_MUL_Y = 32'd57;
  localparam logic [HASH_W-1:0] HASH_MUL_Z = 32'd3251;
  localparam int                HASH_SHL   = 13;
  localparam logic [HASH_W-1:0] HASH_MUL_A = 32'd15731;
  localparam logic [HASH_W-1:0] HASH_ADD_A = 32'd789221;
  localparam logic [HASH_W-1:0] HASH_ADD_B = 32'd1376312589;

  // one item moving along the chain
  typedef struct packed {
    logic                     valid;
    logic signed [SNAP_W-1:0] pos_x;
    logic signed [SNAP_W-1:0] pos_y;
    logic signed [SNAP_W-1:0] pos_z;
    logic signed [ACC_W-1:0]  acc;
  } item_t;

  // linear blend of two noise values, c in Q0.16
  function automatic logic [NOISE_W-1:0] lerp16(input logic [NOISE_W-1:0] a,
                                                 input logic [NOISE_W-1:0] b,
                                                 input logic [NOISE_W-1:0] c);
    logic [NOISE_W:0]     ic;
    logic [2*NOISE_W+1:0] s;
    ic = {1'b1, {NOISE_W{1'b0}}} - {1'b0, c};
    s  = (2*NOISE_W+2)'(a) * (2*NOISE_W+2)'(ic) + (2*NOISE_W+2)'(b) * (2*NOISE_W+2)'(c);
    return s[2*NOISE_W-1:NOISE_W];
  endfunction

endpackage

// File: rtl/core/fractal_value_noise.sv
// fractal value noise sampler top level: config port, snapping, octave cell chain, output
// The block takes one 3D point per cycle unless a finished result waits at a blocked output,
// and returns one saturated noise intensity per point, in order, through one snapping stage,
// four octave cells of nine stages each and the output register. Each cell holds eight
// four-stage lattice hash pipelines and three blend stages; the whole chain streams.
// Random and smooth modes use the first cell only, the fractal mode sums all four octaves.
// Registers: 0 noise_mode (0 random, 1 smooth, 2 fractal, 3 gives zero), 1 scale_log2
// (values above 12 act as 12), 2 persistence (Q1.15); write them only while the block is idle.
module fractal_value_noise (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fvn_pkg::ADDR_W-1:0]          paddr,
  input  logic [fvn_pkg::DATA_W-1:0]          pwdata,
  output logic [fvn_pkg::DATA_W-1:0]          prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [fvn_pkg::COORD_BITS-1:0] pos_x_i,
  input  logic signed [fvn_pkg::COORD_BITS-1:0] pos_y_i,
  input  logic signed [fvn_pkg::COORD_BITS-1:0] pos_z_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [fvn_pkg::OUT_W-1:0]    intensity_o
);

  logic [fvn_pkg::MODE_W-1:0]        mode_q;
  logic [fvn_pkg::SCALE_W-1:0]       scale_q;
  logic [fvn_pkg::PERS_W-1:0]        pers_q;
  logic [fvn_pkg::WGT_W-1:0]         p2_q, p3_q;
  logic [2*fvn_pkg::WGT_W-1:0]       p2_prod, p3_prod;
  logic                              wr_en;
  logic                              en;
  logic [fvn_pkg::SCALE_W-1:0]       lg;
  logic [fvn_pkg::SHIFT_W-1:0]       k;
  logic [fvn_pkg::SNAP_W-1:0]        half;
  logic signed [fvn_pkg::SNAP_W-1:0] v [3];
  logic signed [fvn_pkg::SNAP_W-1:0] sv [3];
  logic signed [fvn_pkg::SNAP_W-1:0] sel [3];
  fvn_pkg::item_t                    entry_d, entry_q;
  fvn_pkg::item_t                    chain [fvn_pkg::NUM_CELLS+1];
  logic [fvn_pkg::SCALE_W-1:0]       cell_scale [fvn_pkg::NUM_CELLS];
  logic [fvn_pkg::WGT_W-1:0]         cell_weight [fvn_pkg::NUM_CELLS];
  logic                              cell_add [fvn_pkg::NUM_CELLS];
  logic signed [fvn_pkg::ACC_W-1:0]  res;
  logic                              out_valid_q;
  logic signed [fvn_pkg::OUT_W-1:0]  intensity_q;
  logic                              last_valid;

  // configuration registers
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= fvn_pkg::MODE_RANDOM;
      scale_q <= fvn_pkg::SCALE_RESET;
      pers_q  <= fvn_pkg::PERS_RESET;
    end else if (wr_en) begin
      case (paddr[3:2])
        fvn_pkg::REG_MODE:  mode_q  <= pwdata[fvn_pkg::MODE_W-1:0];
        fvn_pkg::REG_SCALE: scale_q <= pwdata[fvn_pkg::SCALE_W-1:0];
        fvn_pkg::REG_PERS:  pers_q  <= pwdata[fvn_pkg::PERS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      fvn_pkg::REG_MODE:  prdata = fvn_pkg::DATA_W'(mode_q);
      fvn_pkg::REG_SCALE: prdata = fvn_pkg::DATA_W'(scale_q);
      fvn_pkg::REG_PERS:  prdata = fvn_pkg::DATA_W'(pers_q);
      default:            prdata = '0;
    endcase
  end

  // persistence powers, one multiply per register
  assign p2_prod = fvn_pkg::WGT_W'(pers_q) * fvn_pkg::WGT_W'(pers_q);
  assign p3_prod = p2_q * fvn_pkg::WGT_W'(pers_q);

  always_ff @(posedge clk_i) begin
    p2_q <= fvn_pkg::WGT_W'(p2_prod >> fvn_pkg::WGT_FRAC);
    p3_q <= fvn_pkg::WGT_W'(p3_prod >> fvn_pkg::WGT_FRAC);
  end

  // stall only when a finished result sits in the last stage and the output is blocked
  assign last_valid = chain[fvn_pkg::NUM_CELLS].valid;
  assign en         = !last_valid || !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // snap to the nearest multiple of the resolution, half up (smooth mode takes the raw position)
  assign lg   = (scale_q > fvn_pkg::SCALE_LIMIT) ? fvn_pkg::SCALE_LIMIT : scale_q;
  assign k    = fvn_pkg::SHIFT_W'(lg) + fvn_pkg::SHIFT_W'(fvn_pkg::FRAC_BITS);
  assign half = ({{(fvn_pkg::SNAP_W-1){1'b0}}, 1'b1} << k) >> 1;
  assign v[0] = fvn_pkg::SNAP_W'(pos_x_i);
  assign v[1] = fvn_pkg::SNAP_W'(pos_y_i);
  assign v[2] = fvn_pkg::SNAP_W'(pos_z_i);

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sv[a]  = (v[a] + $signed(half)) & $signed({fvn_pkg::SNAP_W{1'b1}} << k);
      sel[a] = (mode_q == fvn_pkg::MODE_SMOOTH) ? v[a] : sv[a];
    end
    entry_d.valid = in_valid_i;
    entry_d.pos_x = sel[0];
    entry_d.pos_y = sel[1];
    entry_d.pos_z = sel[2];
    entry_d.acc   = (mode_q == fvn_pkg::MODE_FRACTAL) ? fvn_pkg::ACC_SEED_FRACTAL
                                                      : fvn_pkg::ACC_SEED_PLAIN;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (en) begin
      entry_q <= entry_d;
    end
  end

  // cell settings: the first cell also serves random and smooth modes
  always_comb begin
    for (int c = 0; c < fvn_pkg::NUM_CELLS; c++) begin
      cell_scale[c] = fvn_pkg::OCT_SCALE[c];
      cell_add[c]   = (mode_q == fvn_pkg::MODE_FRACTAL);
    end
    cell_scale[0]  = (mode_q == fvn_pkg::MODE_FRACTAL) ? fvn_pkg::OCT_SCALE[0] : lg;
    cell_add[0]    = 1'b1;
    cell_weight[0] = fvn_pkg::WEIGHT_ONE;
    cell_weight[1] = fvn_pkg::WGT_W'(pers_q);
    cell_weight[2] = p2_q;
    cell_weight[3] = p3_q;
  end

  // chain of octave cells
  assign chain[0] = entry_q;

  for (genvar c = 0; c < fvn_pkg::NUM_CELLS; c++) begin : g_cell
    fvn_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .scale_i  (cell_scale[c]),
      .weight_i (cell_weight[c]),
      .add_en_i (cell_add[c]),
      .item_i   (chain[c]),
      .item_o   (chain[c+1])
    );
  end

  // final scaling and saturation
  always_comb begin
    case (mode_q)
      fvn_pkg::MODE_RANDOM,
      fvn_pkg::MODE_SMOOTH:  res = chain[fvn_pkg::NUM_CELLS].acc;
      fvn_pkg::MODE_FRACTAL: res = (chain[fvn_pkg::NUM_CELLS].acc >>> 1) - fvn_pkg::OUT_BIAS;
      default:               res = '0;
    endcase
    if (res > fvn_pkg::OUT_MAX) begin
      res = fvn_pkg::OUT_MAX;
    end else if (res < fvn_pkg::OUT_MIN) begin
      res = fvn_pkg::OUT_MIN;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= last_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      intensity_q <= fvn_pkg::OUT_W'(res);
    end
  end

  assign out_valid_o = out_valid_q;
  assign intensity_o = intensity_q;

  // an accepted transaction enters the snapping stage
  a_entry_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> entry_q.valid)
    else $error("accepted transaction missing from entry stage");

  // input stalls only behind a blocked finished result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i && last_valid)
    else $error("input stalled without a blocked result");

  // unused mode gives zero
  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_q == fvn_pkg::MODE_UNUSED |-> intensity_o == '0)
    else $error("unused mode produced nonzero intensity");

  // single lattice modes stay within one hash value range
  a_plain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_q == fvn_pkg::MODE_RANDOM || mode_q == fvn_pkg::MODE_SMOOTH)
    |-> !intensity_o[fvn_pkg::OUT_W-1] && intensity_o[fvn_pkg::OUT_W-2:fvn_pkg::NOISE_W] == '0)
    else $error("plain noise out of range");

endmodule

// File: rtl/core/fvn_hash.sv
// four-stage lattice hash of one integer corner
module fvn_hash (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [fvn_pkg::HASH_W-1:0]     ix_i,
  input  logic [fvn_pkg::HASH_W-1:0]     iy_i,
  input  logic [fvn_pkg::HASH_W-1:0]     iz_i,
  output logic [fvn_pkg::NOISE_W-1:0]    noise_o
);

  logic [fvn_pkg::HASH_W-1:0]  sum;
  logic [fvn_pkg::HASH_W-1:0]  mix;
  logic [fvn_pkg::HASH_W-1:0]  fin;
  logic [fvn_pkg::HASH_W-1:0]  n1_q, n2_q, n3_q, sq_q, t_q;
  logic [fvn_pkg::NOISE_W-1:0] h_q;

  // linear mix of the corner and the shift-xor
  assign sum = ix_i + iy_i * fvn_pkg::HASH_MUL_Y + iz_i * fvn_pkg::HASH_MUL_Z;
  assign mix = (sum << fvn_pkg::HASH_SHL) ^ sum;
  assign fin = n3_q * t_q + fvn_pkg::HASH_ADD_B;

  // register the mix, then square, polynomial and final product, one multiply each
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n1_q <= mix;
      sq_q <= n1_q * n1_q;
      n2_q <= n1_q;
      t_q  <= sq_q * fvn_pkg::HASH_MUL_A + fvn_pkg::HASH_ADD_A;
      n3_q <= n2_q;
      h_q  <= fin[30:15];
    end
  end

  assign noise_o = h_q;

endmodule

// File: rtl/core/fvn_cell.sv
// one octave cell: trilinear value noise at the scale on scale_i, adds its weighted term if add_en_i
module fvn_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic [fvn_pkg::SCALE_W-1:0]      scale_i,
  input  logic [fvn_pkg::WGT_W-1:0]        weight_i,
  input  logic                             add_en_i,
  input  fvn_pkg::item_t                   item_i,
  output fvn_pkg::item_t                   item_o
);

  typedef struct packed {
    fvn_pkg::item_t                    item;
    logic [2:0][fvn_pkg::NOISE_W-1:0]  fr;
  } side_t;

  localparam int WIDE_W = fvn_pkg::SNAP_W + fvn_pkg::NOISE_W;
  localparam int PROD_W = fvn_pkg::NOISE_W + fvn_pkg::WGT_W + 2;

  logic [fvn_pkg::SHIFT_W-1:0]       k;
  logic signed [fvn_pkg::SNAP_W-1:0] pos [3];
  logic signed [fvn_pkg::SNAP_W-1:0] q [3];
  logic [fvn_pkg::SNAP_W-1:0]        rem [3];
  logic [WIDE_W-1:0]                 wide [3];
  logic [fvn_pkg::HASH_W-1:0]        lo_d [3];
  logic [fvn_pkg::HASH_W-1:0]        hi_d [3];
  logic [fvn_pkg::HASH_W-1:0]        lo_q [3];
  logic [fvn_pkg::HASH_W-1:0]        hi_q [3];
  side_t                             side_d;
  side_t                             side_q [fvn_pkg::CELL_STAGES];
  logic [fvn_pkg::NOISE_W-1:0]       noise [fvn_pkg::LANES];
  logic [fvn_pkg::NOISE_W-1:0]       lz_q [4];
  logic [fvn_pkg::NOISE_W-1:0]       ly_q [2];
  logic [fvn_pkg::NOISE_W-1:0]       lx_q;
  logic signed [fvn_pkg::NOISE_W:0]  diff;
  logic signed [PROD_W-1:0]          prod;
  logic signed [fvn_pkg::ACC_W-1:0]  term;
  side_t                             acc_side;

  // cell position, fraction and corner lattice coordinates
  assign k      = fvn_pkg::SHIFT_W'(scale_i) + fvn_pkg::SHIFT_W'(fvn_pkg::FRAC_BITS);
  assign pos[0] = item_i.pos_x;
  assign pos[1] = item_i.pos_y;
  assign pos[2] = item_i.pos_z;

  always_comb begin
    side_d.item = item_i;
    for (int a = 0; a < 3; a++) begin
      q[a]         = pos[a] >>> k;
      rem[a]       = pos[a] & ~({fvn_pkg::SNAP_W{1'b1}} << k);
      wide[a]      = {rem[a], {fvn_pkg::NOISE_W{1'b0}}} >> k;
      side_d.fr[a] = wide[a][fvn_pkg::NOISE_W-1:0];
      lo_d[a]      = fvn_pkg::HASH_W'(q[a]) << scale_i;
      hi_d[a]      = lo_d[a] + (fvn_pkg::HASH_W'(1) << scale_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < 3; a++) begin
        lo_q[a] <= lo_d[a];
        hi_q[a] <= hi_d[a];
      end
    end
  end

  // eight corner hashes, corner bits are x, y, z from high to low
  for (genvar c = 0; c < fvn_pkg::LANES; c++) begin : g_corner
    fvn_hash u_hash (
      .clk_i   (clk_i),
      .en_i    (en_i),
      .ix_i    (c[2] ? hi_q[0] : lo_q[0]),
      .iy_i    (c[1] ? hi_q[1] : lo_q[1]),
      .iz_i    (c[0] ? hi_q[2] : lo_q[2]),
      .noise_o (noise[c])
    );
  end

  // blends along z, y, x
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 4; j++) begin
        lz_q[j] <= fvn_pkg::lerp16(noise[2*j], noise[2*j+1], side_q[4].fr[2]);
      end
      for (int j = 0; j < 2; j++) begin
        ly_q[j] <= fvn_pkg::lerp16(lz_q[2*j], lz_q[2*j+1], side_q[5].fr[1]);
      end
      lx_q <= fvn_pkg::lerp16(ly_q[0], ly_q[1], side_q[6].fr[0]);
    end
  end

  // weighted octave term into the running sum
  always_comb begin
    diff = $signed({1'b0, lx_q}) - fvn_pkg::NOISE_BIAS;
    prod = PROD_W'(diff) * PROD_W'($signed({1'b0, weight_i}));
    term = fvn_pkg::ACC_W'(prod >>> fvn_pkg::WGT_FRAC);
    acc_side = side_q[7];
    if (add_en_i) begin
      acc_side.item.acc = side_q[7].item.acc + term;
    end
  end

  // item and fractions travel beside the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < fvn_pkg::CELL_STAGES; s++) begin
        side_q[s] <= '0;
      end
    end else if (en_i) begin
      side_q[0] <= side_d;
      for (int s = 1; s < fvn_pkg::CELL_STAGES - 1; s++) begin
        side_q[s] <= side_q[s-1];
      end
      side_q[fvn_pkg::CELL_STAGES-1] <= acc_side;
    end
  end

  assign item_o = side_q[fvn_pkg::CELL_STAGES-1].item;

endmodule

// File: bench/fvn_checker.sv
// checker for the fractal value noise block: predicts intensities and compares them
module fvn_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [fvn_pkg::ADDR_W-1:0]            paddr,
  input  logic [fvn_pkg::DATA_W-1:0]            pwdata,
  input  logic                                  pready,
  input  logic                                  in_valid_i,
  input  logic                                  in_ready_i,
  input  logic signed [fvn_pkg::COORD_BITS-1:0] pos_x_i,
  input  logic signed [fvn_pkg::COORD_BITS-1:0] pos_y_i,
  input  logic signed [fvn_pkg::COORD_BITS-1:0] pos_z_i,
  input  logic                                  out_valid_i,
  input  logic                                  out_ready_i,
  input  logic signed [fvn_pkg::OUT_W-1:0]      intensity_i,
  output int                                    mismatch_count_o,
  output int                                    pending_count_o
);

  logic [fvn_pkg::MODE_W-1:0]  mode_q;
  logic [fvn_pkg::SCALE_W-1:0] scale_q;
  logic [fvn_pkg::PERS_W-1:0]  pers_q;
  logic signed [fvn_pkg::OUT_W-1:0] intensity_q[$];

  // 32-bit lattice hash, returns Q0.16
  function automatic longint hash_corner(longint ix, longint iy, longint iz);
    logic [31:0] n;
    n = 32'(ix) + 32'(iy) * 32'd57 + 32'(iz) * 32'd3251;
    n = (n << 13) ^ n;
    n = n * ((n * n) * 32'd15731 + 32'd789221) + 32'd1376312589;
    return longint'(n[30:15]);
  endfunction

  function automatic longint blend(longint a, longint b, longint c);
    return (a * (65536 - c) + b * c) >>> 16;
  endfunction

  // trilinear noise at cell size 2^lg world units
  function automatic longint trilinear(longint vx, longint vy, longint vz, int lg);
    longint v[3], lo[3], hi[3], fr[3], q, rem, zv[2], yv[2], cx, cy;
    int k;
    k = lg + fvn_pkg::FRAC_BITS;
    v[0] = vx; v[1] = vy; v[2] = vz;
    for (int i = 0; i < 3; i++) begin
      q = v[i] >>> k;
      rem = v[i] - (q <<< k);
      fr[i] = (k > 16) ? (rem >>> (k - 16)) : (rem <<< (16 - k));
      lo[i] = q <<< lg;
      hi[i] = lo[i] + (longint'(1) <<< lg);
    end
    for (int x = 0; x < 2; x++) begin
      cx = x ? hi[0] : lo[0];
      for (int y = 0; y < 2; y++) begin
        cy = y ? hi[1] : lo[1];
        zv[y] = blend(hash_corner(cx, cy, lo[2]), hash_corner(cx, cy, hi[2]), fr[2]);
      end
      yv[x] = blend(zv[0], zv[1], fr[1]);
    end
    return blend(yv[0], yv[1], fr[0]);
  endfunction

  function automatic longint snap_round(longint v, int k);
    return ((v + (longint'(1) <<< (k - 1))) >>> k) <<< k;
  endfunction

  function automatic longint weigh_octave(longint n, longint w);
    return ((n - 32768) * w) >>> 15;
  endfunction

  function automatic logic signed [fvn_pkg::OUT_W-1:0] predict_intensity(longint vx,
                                                                        longint vy,
                                                                        longint vz);
    longint sx, sy, sz, r, p, p2, p3, n;
    int lg, k;
    lg = (scale_q > fvn_pkg::SCALE_LIMIT) ? fvn_pkg::MAX_SCALE : int'(scale_q);
    k = lg + fvn_pkg::FRAC_BITS;
    sx = snap_round(vx, k);
    sy = snap_round(vy, k);
    sz = snap_round(vz, k);
    r = 0;
    case (mode_q)
      fvn_pkg::MODE_RANDOM: r = hash_corner(sx >>> fvn_pkg::FRAC_BITS, sy >>> fvn_pkg::FRAC_BITS,
                                            sz >>> fvn_pkg::FRAC_BITS);
      fvn_pkg::MODE_SMOOTH: r = trilinear(vx, vy, vz, lg);
      fvn_pkg::MODE_FRACTAL: begin
        p  = longint'(pers_q);
        p2 = (p * p) >>> 15;
        p3 = (p2 * p) >>> 15;
        n  = trilinear(sx, sy, sz, 10) + 98304;
        n += weigh_octave(trilinear(sx, sy, sz, 8), p);
        n += weigh_octave(trilinear(sx, sy, sz, 6), p2);
        n += weigh_octave(trilinear(sx, sy, sz, 4), p3);
        r = (n >>> 1) - 32768;
      end
      default: r = 0;
    endcase
    if (r > 524287) r = 524287;
    if (r < -524288) r = -524288;
    return fvn_pkg::OUT_W'(r);
  endfunction

  assign pending_count_o = intensity_q.size();

  // track register writes, predict on input transactions, compare on output ones
  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [fvn_pkg::OUT_W-1:0] want;
    if (!rst_ni) begin
      mode_q <= fvn_pkg::MODE_RANDOM;
      scale_q <= fvn_pkg::SCALE_RESET;
      pers_q <= fvn_pkg::PERS_RESET;
      mismatch_count_o <= 0;
      intensity_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          fvn_pkg::REG_MODE:  mode_q <= pwdata[fvn_pkg::MODE_W-1:0];
          fvn_pkg::REG_SCALE: scale_q <= pwdata[fvn_pkg::SCALE_W-1:0];
          fvn_pkg::REG_PERS:  pers_q <= pwdata[fvn_pkg::PERS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        intensity_q.push_back(predict_intensity(longint'(pos_x_i), longint'(pos_y_i),
                                                longint'(pos_z_i)));
      if (out_valid_i && out_ready_i) begin
        if (intensity_q.size() == 0) begin
          if (mismatch_count_o < 10)
            $display("unexpected result: intensity %0d", intensity_i);
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          want = intensity_q.pop_front();
          if (want !== intensity_i) begin
            if (mismatch_count_o < 10)
              $display("intensity mismatch: expected %0d, got %0d", want, intensity_i);
            mismatch_count_o <= mismatch_count_o + 1;
          end
        end
      end
    end
  end

endmodule

// File: bench/fractal_value_noise_test.sv
// testbench top for the fractal value noise block: stimulus, watchdog and verdict
module fractal_value_noise_test;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite, pready;
  logic [fvn_pkg::ADDR_W-1:0] paddr;
  logic [fvn_pkg::DATA_W-1:0] pwdata, prdata;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic signed [fvn_pkg::COORD_BITS-1:0] pos_x_i, pos_y_i, pos_z_i;
  logic signed [fvn_pkg::OUT_W-1:0] intensity_o;
  int mismatch_count, pending_count, quiet_cycles;
  bit calm, hold_req;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;

  fractal_value_noise DUT (.*);

  fvn_checker checker_i (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid_i, .in_ready_i(in_ready_o), .pos_x_i, .pos_y_i, .pos_z_i,
    .out_valid_i(out_valid_o), .out_ready_i, .intensity_i(intensity_o),
    .mismatch_count_o(mismatch_count), .pending_count_o(pending_count)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ready_i = 0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_ready_i <= 0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 0;
      end else begin
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
          out_ready_i <= 0;
          repeat (gap) @(posedge clk_i);
        end
        out_ready_i <= 1;
        do @(posedge clk_i); while (!out_valid_o);
      end
    end
  end

  task automatic reg_write(input logic [1:0] idx, input int unsigned val);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= fvn_pkg::ADDR_W'({idx, 2'b00}); pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk_i);
  endtask

  task automatic send_point(input logic [fvn_pkg::COORD_BITS-1:0] x, y, z, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : draw_gap();
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    pos_x_i <= x; pos_y_i <= y; pos_z_i <= z;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic logic [fvn_pkg::COORD_BITS-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return fvn_pkg::COORD_BITS'($urandom_range(0, 4095)) - 12'd2048;
      1: return $urandom_range(0, 1) ? {1'b0, {(fvn_pkg::COORD_BITS-1){1'b1}}}
                                     : {1'b1, {(fvn_pkg::COORD_BITS-1){1'b0}}};
      default: return fvn_pkg::COORD_BITS'($urandom());
    endcase
  endfunction

  // wait for all results, then reprogram
  task automatic set_config(input logic [fvn_pkg::MODE_W-1:0] mode,
                            input int unsigned scale, pers);
    in_valid_i <= 0;
    wait (pending_count == 0);
    @(posedge clk_i);
    reg_write(fvn_pkg::REG_MODE, 32'(mode));
    reg_write(fvn_pkg::REG_SCALE, scale);
    reg_write(fvn_pkg::REG_PERS, pers);
  endtask

  initial begin
    logic [fvn_pkg::COORD_BITS-1:0] pmax, pmin;
    logic [fvn_pkg::MODE_W-1:0] dmodes[4];
    logic [fvn_pkg::MODE_W-1:0] modes[10];
    int unsigned scales[10];
    int unsigned perss[10];
    dmodes = '{fvn_pkg::MODE_RANDOM, fvn_pkg::MODE_SMOOTH, fvn_pkg::MODE_FRACTAL,
               fvn_pkg::MODE_UNUSED};
    modes = '{fvn_pkg::MODE_RANDOM, fvn_pkg::MODE_SMOOTH, fvn_pkg::MODE_FRACTAL,
              fvn_pkg::MODE_FRACTAL, fvn_pkg::MODE_SMOOTH, fvn_pkg::MODE_RANDOM,
              fvn_pkg::MODE_FRACTAL, fvn_pkg::MODE_UNUSED, fvn_pkg::MODE_SMOOTH,
              fvn_pkg::MODE_FRACTAL};
    scales = '{0, 12, 5, 15, 0, 13, 9, 3, 7, 0};
    perss = '{0, 65535, 16384, 0, 32768, 1, 65535, 777, 40000, 32768};
    pmax = {1'b0, {(fvn_pkg::COORD_BITS-1){1'b1}}};
    pmin = {1'b1, {(fvn_pkg::COORD_BITS-1){1'b0}}};
    rst_ni = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid_i = 0; pos_x_i = 0; pos_y_i = 0; pos_z_i = 0;
    calm = 0; hold_req = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed points: zero, extremes, half-cell, negative, mixed, in every mode
    for (int m = 0; m < 4; m++) begin
      set_config(dmodes[m], (dmodes[m] == fvn_pkg::MODE_SMOOTH) ? 12 : 5,
                 (dmodes[m] == fvn_pkg::MODE_FRACTAL) ? 65535 : 16384);
      send_point('0, '0, '0, 1'b0);
      send_point(pmax, pmax, pmax, 1'b0);
      send_point(pmin, pmin, pmin, 1'b0);
      send_point(20'd256, 20'd255, 20'd257, 1'b0);
      send_point(-20'sd1, -20'sd16, -20'sd512, 1'b0);
      send_point(pmax, pmin, 20'd12345, 1'b0);
    end

    // random phases over a spread of register settings
    for (int ph = 0; ph < 10; ph++) begin
      set_config(modes[ph], scales[ph], perss[ph]);
      calm = (ph == 2 || ph == 6);
      if (ph == 4) hold_req = 1;
      for (int i = 0; i < 190; i++)
        send_point(rand_coord(), rand_coord(), rand_coord(), ph == 4);
    end
    in_valid_i <= 0;
    wait (pending_count == 0);
    repeat (50) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
